// ===== rtl/spq_pkg.sv =====
// Package with the shared types, constants and codes of the stable priority queue.
`default_nettype none

package spq_pkg;

    localparam int DEPTH         = 16;
    localparam int ID_BITS       = 8;
    localparam int PRIORITY_BITS = 8;
    localparam int OCC_BITS      = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_ISSUE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_POP
    } cell_mode_t;

    typedef enum logic {
        CTL_IDLE,
        CTL_REINSERT
    } ctl_state_t;

    typedef struct packed {
        logic [1:0]               operation;
        logic [ID_BITS-1:0]       entry_id;
        logic [PRIORITY_BITS-1:0] priority_req;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [ID_BITS-1:0]       issued_id;
        logic [PRIORITY_BITS-1:0] issued_priority;
        logic [OCC_BITS-1:0]      occupancy;
    } out_item_t;

    typedef struct packed {
        logic [ID_BITS-1:0]       id;
        logic [PRIORITY_BITS-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } slot_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
`default_nettype none

module spq_cell (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire spq_pkg::cell_mode_t mode,
    input  wire spq_pkg::entry_t     key,
    input  wire spq_pkg::slot_t      left_slot,
    input  wire logic                left_gt,
    input  wire spq_pkg::slot_t      right_slot,
    input  wire logic                hit_in,
    output spq_pkg::slot_t           slot,
    output logic                     gt,
    output logic                     hit_out
);
    import spq_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic   match;
    logic   take;

    assign slot    = '{valid: valid_reg, entry: entry_reg};
    assign gt      = valid_reg && (entry_reg.prio > key.prio);
    assign match   = valid_reg && (entry_reg.id == key.id);
    assign hit_out = hit_in || match;
    assign take    = hit_in || match || (mode == CELL_POP);

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        unique case (mode)
            CELL_HOLD: begin
            end
            CELL_INSERT: begin
                // Entries behind the insertion point move one cell toward the tail.
                if (left_gt) begin
                    valid_next = left_slot.valid;
                    entry_next = left_slot.entry;
                end else if ((gt || !valid_reg) && left_slot.valid) begin
                    valid_next = 1'b1;
                    entry_next = key;
                end
            end
            CELL_REMOVE, CELL_POP: begin
                if (take) begin
                    valid_next = right_slot.valid;
                    entry_next = right_slot.entry;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ===== rtl/stable_priority_queue_unit.sv =====
// Top level of the stable priority queue: control, result register and the cell chain.
//
//   channel  direction  payload      handshake
//   s_       in         in_item_t    s_valid / s_ready
//   m_       out        out_item_t   m_valid / m_ready
//
// Insert, remove and issue act on the chain directly: every cell compares against the key in
// parallel and shifts by one place toward or away from the head.
// Update is a remove pass through the chain followed by an insert pass.
// The result is registered; a new item is accepted while no update is in its insert pass
// and the result register is free or being emptied in the same cycle.
// Reset empties the queue at once; no clearing pass is needed.
`default_nettype none

module stable_priority_queue_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire spq_pkg::in_item_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output spq_pkg::out_item_t     m_data
);
    import spq_pkg::*;

    ctl_state_t          state_reg;
    ctl_state_t          state_next;
    logic [OCC_BITS-1:0] count_reg;
    logic [OCC_BITS-1:0] count_next;
    entry_t              pend_reg;
    entry_t              pend_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    out_item_t           m_data_reg;
    out_item_t           m_data_next;

    cell_mode_t          cell_mode;
    entry_t              cell_key;
    logic                accept;
    logic                found;
    logic                res_load;
    out_item_t           res;

    slot_t               slots [DEPTH];
    logic                gts   [DEPTH];
    logic                hits  [DEPTH];

    assign s_ready = (state_reg == CTL_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign found   = hits[DEPTH-1];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            slot_t left_s;
            slot_t right_s;
            logic  left_g;
            logic  hit_i;
            if (g == 0) begin : g_head
                assign left_s = '{valid: 1'b1, entry: '0};
                assign left_g = 1'b0;
                assign hit_i  = 1'b0;
            end else begin : g_body
                assign left_s = slots[g-1];
                assign left_g = gts[g-1];
                assign hit_i  = hits[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign right_s = '{valid: 1'b0, entry: '0};
            end else begin : g_inner
                assign right_s = slots[g+1];
            end
            spq_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .mode       (cell_mode),
                .key        (cell_key),
                .left_slot  (left_s),
                .left_gt    (left_g),
                .right_slot (right_s),
                .hit_in     (hit_i),
                .slot       (slots[g]),
                .gt         (gts[g]),
                .hit_out    (hits[g])
            );
        end
    endgenerate

    always_comb begin
        if (state_reg == CTL_REINSERT) begin
            cell_key = pend_reg;
        end else begin
            cell_key = '{id: s_data.entry_id, prio: s_data.priority_req};
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        res_load   = 1'b0;
        res        = '0;
        cell_mode  = CELL_HOLD;
        unique case (state_reg)
            CTL_IDLE: begin
                if (accept) begin
                    unique case (op_t'(s_data.operation))
                        OP_INSERT: begin
                            res_load = 1'b1;
                            if (count_reg == OCC_BITS'(DEPTH)) begin
                                res.status = ST_FULL;
                            end else begin
                                cell_mode  = CELL_INSERT;
                                count_next = count_reg + 1'b1;
                                res.status = ST_OK;
                            end
                        end
                        OP_REMOVE: begin
                            res_load = 1'b1;
                            if (found) begin
                                cell_mode  = CELL_REMOVE;
                                count_next = count_reg - 1'b1;
                                res.status = ST_OK;
                            end else begin
                                res.status = ST_NOT_FOUND;
                            end
                        end
                        OP_UPDATE: begin
                            if (found) begin
                                cell_mode  = CELL_REMOVE;
                                count_next = count_reg - 1'b1;
                                pend_next  = cell_key;
                                state_next = CTL_REINSERT;
                            end else begin
                                res_load   = 1'b1;
                                res.status = ST_NOT_FOUND;
                            end
                        end
                        OP_ISSUE: begin
                            res_load = 1'b1;
                            if (count_reg == '0) begin
                                res.status = ST_EMPTY;
                            end else begin
                                cell_mode           = CELL_POP;
                                count_next          = count_reg - 1'b1;
                                res.status          = ST_OK;
                                res.issued_id       = slots[0].entry.id;
                                res.issued_priority = slots[0].entry.prio;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            CTL_REINSERT: begin
                cell_mode  = CELL_INSERT;
                count_next = count_reg + 1'b1;
                res_load   = 1'b1;
                res.status = ST_OK;
                state_next = CTL_IDLE;
            end
            default: begin
                state_next = CTL_IDLE;
            end
        endcase
        res.occupancy = count_next;

        m_data_next = m_data_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CTL_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

// ===== rtl/spq_checker.sv =====
// Port-level checker for the stable priority queue and its bind to the top level.
`default_nettype none

module spq_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire spq_pkg::out_item_t m_data
);
    import spq_pkg::*;

    // A stalled result item holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // Only a successful issue carries a popped entry.
    a_issue_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_OK) |->
            (m_data.issued_id == '0) && (m_data.issued_priority == '0))
        else $error("popped entry reported on a failed operation");

    // A dropped insert only happens when the queue is full.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_FULL) |-> m_data.occupancy == OCC_BITS'(DEPTH))
        else $error("insert dropped while the queue has room");

    // An empty issue only happens when the queue holds nothing.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_EMPTY) |-> m_data.occupancy == '0)
        else $error("issue reported empty on a queue that holds items");

    // Occupancy never exceeds the capacity.
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.occupancy <= OCC_BITS'(DEPTH))
        else $error("occupancy beyond capacity");

endmodule

bind stable_priority_queue_unit spq_checker u_spq_checker (.*);

`default_nettype wire

// ===== dv/tb_stable_priority_queue_unit.sv =====
// Testbench for the stable priority queue: random and directed items checked against a sorted-list predictor.
`default_nettype none

module tb_stable_priority_queue_unit;

    import spq_pkg::*;

    localparam int RANDOM_ITEMS = 1625;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    in_item_t    pending_ops[$];
    out_item_t   expected_outcomes[$];
    entry_t      sorted_entries[$];
    int unsigned mismatch_count = 0;
    int unsigned result_index = 0;
    int unsigned send_wait = 0;
    int unsigned take_wait = 0;
    bit          send_calm = 1'b0;
    bit          take_calm = 1'b0;

    stable_priority_queue_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned draw_wait(bit calm);
        if (calm) begin
            return 0;
        end
        if ($urandom_range(0, 2) == 0) begin
            return $urandom_range(0, 19);
        end
        return $urandom_range(0, 3);
    endfunction

    // New entries go behind every entry of equal or lower priority value.
    function automatic void place_sorted(entry_t ent);
        int pos;
        pos = 0;
        while (pos < sorted_entries.size() && sorted_entries[pos].prio <= ent.prio) begin
            pos++;
        end
        sorted_entries.insert(pos, ent);
    endfunction

    function automatic out_item_t apply_queue_op(in_item_t item);
        out_item_t res;
        entry_t    ent;
        int        hit;
        res = '0;
        res.status = ST_OK;
        ent.id = item.entry_id;
        ent.prio = item.priority_req;
        hit = -1;
        for (int i = 0; i < sorted_entries.size(); i++) begin
            if (hit < 0 && sorted_entries[i].id == item.entry_id) begin
                hit = i;
            end
        end
        case (op_t'(item.operation))
            OP_INSERT: begin
                if (sorted_entries.size() >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    place_sorted(ent);
                end
            end
            OP_REMOVE: begin
                if (hit < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    sorted_entries.delete(hit);
                end
            end
            OP_UPDATE: begin
                if (hit < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    sorted_entries.delete(hit);
                    place_sorted(ent);
                end
            end
            default: begin
                if (sorted_entries.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.issued_id = sorted_entries[0].id;
                    res.issued_priority = sorted_entries[0].prio;
                    void'(sorted_entries.pop_front());
                end
            end
        endcase
        res.occupancy = OCC_BITS'(sorted_entries.size());
        return res;
    endfunction

    function automatic void push_op(op_t op, logic [ID_BITS-1:0] id,
                                    logic [PRIORITY_BITS-1:0] prio);
        in_item_t item;
        item.operation = op;
        item.entry_id = id;
        item.priority_req = prio;
        pending_ops.push_back(item);
    endfunction

    function automatic void flag_error(string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch: %s", what);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
            send_wait <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_outcomes.push_back(apply_queue_op(s_data));
            end
            if (!s_valid || s_ready) begin
                if (send_wait != 0) begin
                    send_wait <= send_wait - 1;
                    s_valid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data <= pending_ops.pop_front();
                    if ($urandom_range(0, 29) == 0) begin
                        send_calm <= !send_calm;
                    end
                    send_wait <= draw_wait(send_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_side
        int unsigned w;
        out_item_t   want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            take_wait <= 0;
        end else if (m_valid && m_ready) begin
            if (expected_outcomes.size() == 0) begin
                flag_error($sformatf("item %0d arrived with nothing expected: %p",
                                     result_index, m_data));
            end else begin
                want = expected_outcomes.pop_front();
                if (m_data.status !== want.status || m_data.issued_id !== want.issued_id
                    || m_data.issued_priority !== want.issued_priority
                    || m_data.occupancy !== want.occupancy) begin
                    flag_error($sformatf(
                        "item %0d expected st=%0d id=%0d pr=%0d occ=%0d got st=%0d id=%0d pr=%0d occ=%0d",
                        result_index, want.status, want.issued_id, want.issued_priority,
                        want.occupancy, m_data.status, m_data.issued_id,
                        m_data.issued_priority, m_data.occupancy));
                end
            end
            result_index++;
            if ($urandom_range(0, 29) == 0) begin
                take_calm <= !take_calm;
            end
            w = draw_wait(take_calm);
            take_wait <= w;
            m_ready <= (w == 0);
        end else if (take_wait != 0) begin
            take_wait <= take_wait - 1;
            m_ready <= (take_wait == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        int unsigned bias;
        int unsigned r;
        int unsigned ins_pct;
        int unsigned rem_pct;
        int unsigned upd_pct;
        logic [ID_BITS-1:0]       id;
        logic [PRIORITY_BITS-1:0] prio;
        op_t op;

        // Empty queue, absent ids, extreme fields, ties and duplicate ids.
        push_op(OP_ISSUE, 8'd0, 8'd0);
        push_op(OP_REMOVE, 8'd5, 8'd0);
        push_op(OP_UPDATE, 8'd5, 8'd9);
        push_op(OP_INSERT, 8'd0, 8'd255);
        push_op(OP_INSERT, 8'd255, 8'd0);
        push_op(OP_INSERT, 8'd7, 8'd100);
        push_op(OP_INSERT, 8'd8, 8'd100);
        push_op(OP_INSERT, 8'd7, 8'd50);
        push_op(OP_UPDATE, 8'd7, 8'd100);
        for (int i = 0; i < 11; i++) begin
            push_op(OP_INSERT, 8'h10 + 8'(i), (i % 2 == 0) ? 8'h55 : 8'hAA);
        end
        // Full queue: a dropped insert, then an update that must still succeed.
        push_op(OP_INSERT, 8'hAA, 8'h55);
        push_op(OP_UPDATE, 8'd255, 8'd255);
        push_op(OP_REMOVE, 8'd7, 8'd0);
        push_op(OP_ISSUE, 8'hFF, 8'hFF);
        push_op(OP_ISSUE, 8'd0, 8'd0);

        bias = 2;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) begin
                bias = $urandom_range(0, 2);
            end
            case (bias)
                0: begin ins_pct = 55; rem_pct = 70; upd_pct = 85; end
                1: begin ins_pct = 20; rem_pct = 45; upd_pct = 60; end
                default: begin ins_pct = 35; rem_pct = 55; upd_pct = 75; end
            endcase
            r = $urandom_range(0, 99);
            if (r < ins_pct) begin
                op = OP_INSERT;
            end else if (r < rem_pct) begin
                op = OP_REMOVE;
            end else if (r < upd_pct) begin
                op = OP_UPDATE;
            end else begin
                op = OP_ISSUE;
            end
            id = ($urandom_range(0, 3) != 0) ? ID_BITS'($urandom_range(0, 7))
                                             : ID_BITS'($urandom_range(0, 255));
            prio = ($urandom_range(0, 4) < 2) ? PRIORITY_BITS'($urandom_range(0, 7))
                                              : PRIORITY_BITS'($urandom_range(0, 255));
            push_op(op, id, prio);
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_ops.size() == 0 && !s_valid && expected_outcomes.size() == 0);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
            $display("** stable_priority_queue_unit: PASSED **");
        end else begin
            $display("** stable_priority_queue_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("** stable_priority_queue_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
